// File: rtl/core/three_coloring_conflict_edges_unit_macros.svh
// ----------------------------------------------------------------------------
// Conflict edge unit assertion macros
// Shorthand for clocked assertions used inside the unit's datapath module.
// ----------------------------------------------------------------------------
`ifndef THREE_COLORING_CONFLICT_EDGES_UNIT_MACROS_SVH
`define THREE_COLORING_CONFLICT_EDGES_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its condition
`define TCCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Conflict edge unit package
// Field widths, operation and color codes, and controller interface types.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Field widths
    localparam int FUNC_W     = 2;
    localparam int VTX_W      = 4;
    localparam int COLOR_W    = 2;
    localparam int COUNT_W    = 7;
    localparam int VC_W       = 5;
    localparam int LIM_W      = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD_EDGE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_COLOR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EVALUATE  = 2'd2;

    // Color codes
    localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd2;
    localparam logic [COLOR_W-1:0] NUM_COLORS  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT   = 1'b1;

    // Register reset values and count ceiling
    localparam logic [VC_W-1:0]    VC_RESET  = 5'd16;
    localparam logic [LIM_W-1:0]   LIM_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_step;
        logic edge_write;
        logic color_write;
        logic scan_init;
        logic scan_step;
        logic emit_single;
        logic emit_edge;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_last;
        logic list_ok;
        logic emit_last;
    } ctl_sts_t;

endpackage

// File: rtl/core/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// Conflict edge unit controller
// Sequences memory clearing, request decode, the pair scan and result output.
// ----------------------------------------------------------------------------
module tcce_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tcce_pkg::FUNC_W-1:0] func,
    input  tcce_pkg::ctl_sts_t         sts,
    output tcce_pkg::ctl_cmd_t         cmd,
    output logic                       busy
);
    import tcce_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take a request only when idle
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Decode commands
    always_comb
    begin
        cmd             = '0;
        cmd.clear_step  = (state_reg == ST_CLEAR);
        cmd.edge_write  = accept && (func == FUNC_ADD_EDGE);
        cmd.color_write = accept && (func == FUNC_SET_COLOR);
        cmd.scan_init   = accept && (func == FUNC_EVALUATE);
        cmd.scan_step   = (state_reg == ST_SCAN);
        cmd.emit_single = (state_reg == ST_DECIDE) && !sts.list_ok;
        cmd.emit_edge   = (state_reg == ST_EMIT);
    end

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd.scan_init)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = sts.list_ok ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/core/tcce_dpath.sv
// ----------------------------------------------------------------------------
// Conflict edge unit datapath
// Adjacency and color memories, pair scan pointer, edge list and result regs.
// ----------------------------------------------------------------------------
`include "three_coloring_conflict_edges_unit_macros.svh"

module tcce_dpath
#(
    parameter int MAX_VERTICES     = 16,
    parameter int MAX_LISTED_EDGES = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcce_pkg::ctl_cmd_t              cmd,
    output tcce_pkg::ctl_sts_t              sts,
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [tcce_pkg::VTX_W-1:0]      vertex_a,
    input  logic [tcce_pkg::VTX_W-1:0]      vertex_b,
    input  logic [tcce_pkg::COLOR_W-1:0]    color_in,
    output logic [tcce_pkg::VTX_W-1:0]      edge_first,
    output logic [tcce_pkg::VTX_W-1:0]      edge_second,
    output logic                            edge_valid,
    output logic                            rejected,
    output logic [tcce_pkg::COUNT_W-1:0]    conflict_count,
    output logic                            last,
    output logic                            result_strobe
);
    import tcce_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1) + 1;
    localparam int LW = (MAX_LISTED_EDGES > 1) ? $clog2(MAX_LISTED_EDGES) : 1;

    // Configuration registers
    logic [VC_W-1:0]  vertex_count_reg;
    logic [LIM_W-1:0] edge_limit_reg;

    // Memories
    logic [MAX_VERTICES-1:0] adj_mem   [MAX_VERTICES];
    logic [COLOR_W-1:0]      color_mem [MAX_VERTICES];
    logic [2*VTX_W-1:0]      list_mem  [MAX_LISTED_EDGES];

    // Clearing pointer
    logic [VW-1:0] clr_ptr_reg;

    // Scan pointer
    logic [COLOR_W-1:0] col_reg;
    logic [CW-1:0]      pi_reg;
    logic [CW-1:0]      pj_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      n_sat;
    logic               issue;

    // Read stage
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [COLOR_W-1:0]      s1_col_reg;
    logic [VW-1:0]           s1_i_reg;
    logic [VW-1:0]           s1_j_reg;
    logic [MAX_VERTICES-1:0] row_q;
    logic [COLOR_W-1:0]      ci_q;
    logic [COLOR_W-1:0]      cj_q;
    logic                    hit;

    // Count and listing
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] lim;
    logic [LW-1:0]      k_reg;

    // Request decode
    logic          a_ok;
    logic          b_ok;
    logic [VW-1:0] a_idx;
    logic [VW-1:0] b_idx;
    logic [VW-1:0] lo_idx;
    logic [VW-1:0] hi_idx;

    // Result registers
    logic [VTX_W-1:0]   edge_first_reg;
    logic [VTX_W-1:0]   edge_second_reg;
    logic               edge_valid_reg;
    logic               rejected_reg;
    logic [COUNT_W-1:0] conflict_count_reg;
    logic               last_reg;
    logic               result_strobe_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VC_RESET;
            edge_limit_reg   <= LIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data[VC_W-1:0];
                CFG_EDGE_LIMIT:   edge_limit_reg   <= cfg_data[LIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Saturate vertex count and edge limit
    assign n_sat = (32'(vertex_count_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                                : CW'(vertex_count_reg);
    assign lim   = (32'(edge_limit_reg) > 32'(MAX_LISTED_EDGES)) ? COUNT_W'(MAX_LISTED_EDGES)
                                                                   : COUNT_W'(edge_limit_reg);

    // Decode request vertices
    assign a_ok   = (32'(vertex_a) < 32'(MAX_VERTICES));
    assign b_ok   = (32'(vertex_b) < 32'(MAX_VERTICES));
    assign a_idx  = VW'(vertex_a);
    assign b_idx  = VW'(vertex_b);
    assign lo_idx = (a_idx < b_idx) ? a_idx : b_idx;
    assign hi_idx = (a_idx < b_idx) ? b_idx : a_idx;

    // Sweep the memories once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_ptr_reg <= '0;
        else if (cmd.clear_step)
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
    end

    // Write and read adjacency and colors; only the upper triangle is kept
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            adj_mem[clr_ptr_reg]   <= '0;
            color_mem[clr_ptr_reg] <= COLOR_RED;
        end
        else
        begin
            if (cmd.edge_write && a_ok && b_ok && (a_idx != b_idx))
                adj_mem[lo_idx][hi_idx] <= 1'b1;
            if (cmd.color_write && a_ok && (color_in < NUM_COLORS))
                color_mem[a_idx] <= color_in;
        end
        row_q <= adj_mem[pi_reg[VW-1:0]];
        ci_q  <= color_mem[pi_reg[VW-1:0]];
        cj_q  <= color_mem[pj_reg[VW-1:0]];
    end

    // Walk colors, then i, then j above i
    assign issue = (pj_reg < n_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            col_reg <= COLOR_RED;
            pi_reg  <= '0;
            pj_reg  <= CW'(1);
            n_reg   <= n_sat;
        end
        else if (cmd.scan_step)
        begin
            priority if (pj_reg + CW'(1) < n_reg)
            begin
                pj_reg <= pj_reg + CW'(1);
            end
            else if (pi_reg + CW'(2) < n_reg)
            begin
                pi_reg <= pi_reg + CW'(1);
                pj_reg <= pi_reg + CW'(2);
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                pi_reg  <= '0;
                pj_reg  <= CW'(1);
            end
        end
    end

    // Track the pair whose memory data arrives next cycle
    assign s1_valid_next = cmd.scan_step && issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg <= col_reg;
        s1_i_reg   <= pi_reg[VW-1:0];
        s1_j_reg   <= pj_reg[VW-1:0];
    end

    // Detect a monochromatic edge
    assign hit = s1_valid_reg && (ci_q == s1_col_reg) && (cj_q == s1_col_reg)
                 && row_q[s1_j_reg];

    // Count conflicts and step the output index
    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            if (hit && (count_reg != COUNT_MAX))
                count_reg <= count_reg + 1'b1;
            if (cmd.emit_edge)
                k_reg <= k_reg + 1'b1;
        end
    end

    // Store the first edges and read them back for output
    always_ff @(posedge clk)
    begin
        if (hit && (count_reg < COUNT_W'(MAX_LISTED_EDGES)))
            list_mem[count_reg[LW-1:0]] <= {VTX_W'(s1_i_reg), VTX_W'(s1_j_reg)};
        if (cmd.emit_edge)
            {edge_first_reg, edge_second_reg} <= list_mem[k_reg];
        else if (cmd.emit_single)
            {edge_first_reg, edge_second_reg} <= '0;
    end

    // Load result fields
    always_ff @(posedge clk)
    begin
        if (cmd.emit_edge || cmd.emit_single)
        begin
            edge_valid_reg     <= cmd.emit_edge;
            rejected_reg       <= cmd.emit_single && (count_reg > lim);
            conflict_count_reg <= count_reg;
            last_reg           <= cmd.emit_single || sts.emit_last;
        end
    end

    // Mark each result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_strobe_reg <= 1'b0;
        else
            result_strobe_reg <= cmd.emit_edge || cmd.emit_single;
    end

    // Report status
    assign sts.clear_done = (clr_ptr_reg == VW'(MAX_VERTICES - 1));
    assign sts.scan_last  = (pj_reg + CW'(1) >= n_reg) && (pi_reg + CW'(2) >= n_reg)
                            && (col_reg == COLOR_BLUE);
    assign sts.list_ok    = (count_reg != '0) && (count_reg <= lim);
    assign sts.emit_last  = (COUNT_W'(k_reg) + 1'b1 == count_reg);

    assign edge_first     = edge_first_reg;
    assign edge_second    = edge_second_reg;
    assign edge_valid     = edge_valid_reg;
    assign rejected       = rejected_reg;
    assign conflict_count = conflict_count_reg;
    assign last           = last_reg;
    assign result_strobe  = result_strobe_reg;

    // A listing runs without gaps up to its last result
    `TCCE_ASSERT_NEXT(a_list_contig, result_strobe_reg && !last_reg, result_strobe_reg, "listing broke off before last result")

    // Listed edges only come from an accepted evaluation
    `TCCE_ASSERT_SAME(a_list_bounded, result_strobe_reg && edge_valid_reg, !rejected_reg && (conflict_count_reg <= COUNT_W'(MAX_LISTED_EDGES)), "edge listed beyond accepted count")

    // No scan pair is in flight once results go out
    `TCCE_ASSERT_SAME(a_scan_drained, cmd.emit_single || cmd.emit_edge, !s1_valid_reg && !cmd.scan_step, "result emitted with scan still active")

    // Each hit below the ceiling adds exactly one to the count
    `TCCE_ASSERT_NEXT(a_hit_counts, hit && (count_reg != COUNT_MAX) && !cmd.scan_init, count_reg == $past(count_reg) + 1'b1, "conflict count missed a hit")

endmodule

// File: rtl/core/three_coloring_conflict_edges_unit.sv
// ----------------------------------------------------------------------------
// Three-coloring conflict edge unit
// Keeps an undirected graph and a color per vertex and, on an evaluate
// request, lists the edges whose two ends share a color, red pairs first,
// then green, then blue, each in ascending (i, j) order with i < j. When
// the conflict count exceeds the edge limit, one rejected result is given
// instead; with no conflicts, one empty result is given. After reset the
// unit clears its memories with busy high. An add edge or set color
// request leaves busy low. An evaluate request keeps busy high through the
// scan and the result output; the scan reads one vertex pair per cycle
// from the color and adjacency memories. Results appear on result_strobe
// for one cycle each, back to back, and cannot be held off; each result
// leaves the cycle after it is issued, so the final one is on the ports in
// the first cycle that busy is low again.
// ----------------------------------------------------------------------------
module three_coloring_conflict_edges_unit
#(
    parameter int MAX_VERTICES     = 16,
    parameter int MAX_LISTED_EDGES = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tcce_pkg::FUNC_W-1:0]     func,
    input  logic [tcce_pkg::VTX_W-1:0]      vertex_a,
    input  logic [tcce_pkg::VTX_W-1:0]      vertex_b,
    input  logic [tcce_pkg::COLOR_W-1:0]    color_in,
    input  logic                            cfg_we,
    input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                            result_strobe,
    output logic [tcce_pkg::VTX_W-1:0]      edge_first,
    output logic [tcce_pkg::VTX_W-1:0]      edge_second,
    output logic                            edge_valid,
    output logic                            rejected,
    output logic [tcce_pkg::COUNT_W-1:0]    conflict_count,
    output logic                            last
);
    import tcce_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    // Sequence requests
    tcce_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Hold the graph and produce results
    tcce_dpath
    #(
        .MAX_VERTICES     (MAX_VERTICES),
        .MAX_LISTED_EDGES (MAX_LISTED_EDGES)
    )
    u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .color_in       (color_in),
        .edge_first     (edge_first),
        .edge_second    (edge_second),
        .edge_valid     (edge_valid),
        .rejected       (rejected),
        .conflict_count (conflict_count),
        .last           (last),
        .result_strobe  (result_strobe)
    );

endmodule
